// ----- rtl/integer_to_radix_text_macros.svh -----
// Assertion macros for the block that checks its own behavior.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ITR_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define ITR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ITR_ASSERT_SAME(label, clk, rst_n, cond, expr, msg)
`define ITR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif

`endif

// ----- rtl/itr_pkg.sv -----
`default_nettype none

package itr_pkg;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam logic [5:0] MIN_RADIX   = 6'd2;
    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [5:0] RESET_RADIX = 6'd10;

    localparam logic [0:0] REG_RADIX = 1'b0;
    localparam logic [0:0] REG_UPPER = 1'b1;

    // Quotient bits resolved per cycle by the divider.
    localparam int DIV_STEP = 4;

    typedef struct packed {
        logic       negative;
        logic       upper;
        logic [5:0] base;
    } ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_OUT
    } state_t;

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] d_ext;
        d_ext = {2'b00, d};
        if (d < 6'd10) begin
            return CHAR_ZERO + d_ext;
        end
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + d_ext - 8'd10;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itr_front.sv -----
`default_nettype none

module itr_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // magnitude
    input  wire logic [0:0]            s_tuser,   // is_negative
    input  wire logic [5:0]            radix,
    input  wire logic                  upper,
    output logic                       job_valid,
    input  wire logic                  job_ready,
    output logic [VALUE_BITS-1:0]      job_value,
    output itr_pkg::ctrl_t             job_ctrl
);

    logic [VALUE_BITS-1:0] value_mem [2];
    itr_pkg::ctrl_t        ctrl_mem  [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push, pop;
    logic [63:0]           mag_ext;
    itr_pkg::ctrl_t        ctrl_in;

    assign mag_ext = {32'd0, s_tdata};

    always_comb
    begin
        ctrl_in.negative = s_tuser[0];
        ctrl_in.upper    = upper;
        if (radix < itr_pkg::MIN_RADIX) begin
            ctrl_in.base = itr_pkg::MIN_RADIX;
        end else if (radix > itr_pkg::MAX_RADIX) begin
            ctrl_in.base = itr_pkg::MAX_RADIX;
        end else begin
            ctrl_in.base = radix;
        end
    end

    assign s_tready  = (count_reg != 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job_value = value_mem[rd_ptr_reg];
    assign job_ctrl  = ctrl_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            value_mem[wr_ptr_reg] <= mag_ext[VALUE_BITS-1:0];
            ctrl_mem[wr_ptr_reg]  <= ctrl_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itr_back.sv -----
`default_nettype none

module itr_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    input  wire logic [VALUE_BITS-1:0] job_value,
    input  wire itr_pkg::ctrl_t        job_ctrl,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // text_char
    output logic                       m_tlast    // last_char
);

    localparam int STEP   = itr_pkg::DIV_STEP;
    localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
    localparam int QW     = CHUNKS * STEP;
    localparam int CW     = $clog2(CHUNKS);
    localparam int AW     = $clog2(VALUE_BITS);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

    itr_pkg::state_t state_reg, state_next;
    itr_pkg::ctrl_t  ctrl_reg, ctrl_next;
    logic [QW-1:0]   quot_reg, quot_next;
    logic [5:0]      rem_reg, rem_next;
    logic [CW-1:0]   chunk_reg, chunk_next;
    logic [AW-1:0]   wr_idx_reg, wr_idx_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;

    logic [5:0]      stack_mem [VALUE_BITS];
    logic [5:0]      rd_data_reg;
    logic            stack_we;

    logic [STEP-1:0] top_bits;
    logic [STEP-1:0] qbits;
    logic [5:0]      rem_step;
    logic [6:0]      trial;
    logic [6:0]      diff;
    logic [QW-1:0]   quot_shift;
    logic            slot_free;

    assign job_ready = (state_reg == itr_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // Restoring division by the base, a few dividend bits per cycle.
    always_comb
    begin
        top_bits = quot_reg[QW-1 -: STEP];
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        diff     = '0;
        for (int i = 0; i < STEP; i++) begin
            trial = {rem_step, top_bits[STEP-1-i]};
            diff  = trial - {1'b0, ctrl_reg.base};
            if (trial >= {1'b0, ctrl_reg.base}) begin
                rem_step          = diff[5:0];
                qbits[STEP-1-i]   = 1'b1;
            end else begin
                rem_step = trial[5:0];
            end
        end
        quot_shift = {quot_reg[QW-STEP-1:0], qbits};
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl_next      = ctrl_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        wr_idx_next    = wr_idx_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        stack_we       = 1'b0;
        case (state_reg)
            itr_pkg::ST_IDLE:
            begin
                if (job_valid) begin
                    ctrl_next   = job_ctrl;
                    quot_next   = QW'(job_value);
                    rem_next    = '0;
                    chunk_next  = '0;
                    wr_idx_next = '0;
                    state_next  = itr_pkg::ST_DIV;
                end
            end
            itr_pkg::ST_DIV:
            begin
                quot_next  = quot_shift;
                rem_next   = rem_step;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == LAST_CHUNK) begin
                    stack_we    = 1'b1;
                    chunk_next  = '0;
                    rem_next    = '0;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    ptr_next    = wr_idx_reg;
                    if (quot_shift == '0) begin
                        state_next = ctrl_reg.negative ? itr_pkg::ST_SIGN
                                                       : itr_pkg::ST_READ;
                    end
                end
            end
            itr_pkg::ST_SIGN:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = itr_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = itr_pkg::ST_READ;
                end
            end
            itr_pkg::ST_READ:
            begin
                state_next = itr_pkg::ST_OUT;
            end
            itr_pkg::ST_OUT:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = itr_pkg::digit_char(rd_data_reg, ctrl_reg.upper);
                    out_last_next  = (ptr_reg == '0);
                    if (ptr_reg == '0) begin
                        state_next = itr_pkg::ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = itr_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = itr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= itr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            wr_idx_reg    <= '0;
            ptr_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chunk_reg     <= chunk_next;
            wr_idx_reg    <= wr_idx_next;
            ptr_reg       <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we) begin
            stack_mem[wr_idx_reg] <= rem_step;
        end
        rd_data_reg <= stack_mem[ptr_reg];
    end

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_text.sv -----
// Integer to text converter in a configurable base.
// The input channel (s_*) takes one item per number: s_tdata carries the
// unsigned magnitude and s_tuser the sign flag. The output channel (m_*)
// returns the ASCII characters of that number, most significant digit first,
// with a leading minus sign when the flag is set; m_tlast marks the final one.
// The base (2 to 36, clamped) and the letter case are written through the
// cfg_we, cfg_addr and cfg_wdata port; the user must write them only while
// no number is in flight, as the block itself does not enforce it.
// A two-entry queue holds accepted items while the converter works.
// Each digit comes from the shared divider, which resolves four quotient
// bits per cycle; each character is then read from the digit stack and
// loaded into the output register.
// Reset empties the queue, drops any output item and sets base 10 with lower
// case letters. When m_tready is low, the current character holds and the
// converter waits; the queue keeps taking items until it is full.
`default_nettype none

module integer_to_radix_text #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // magnitude
    input  wire logic [0:0]  s_tuser,   // is_negative
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // text_char
    output logic             m_tlast    // last_char
);

`include "integer_to_radix_text_macros.svh"

    logic [5:0]            radix_reg, radix_next;
    logic                  upper_reg, upper_next;
    logic                  job_valid;
    logic                  job_ready;
    logic [VALUE_BITS-1:0] job_value;
    itr_pkg::ctrl_t        job_ctrl;

    always_comb
    begin
        radix_next = radix_reg;
        upper_next = upper_reg;
        if (cfg_we) begin
            case (cfg_addr)
                itr_pkg::REG_RADIX: radix_next = cfg_wdata;
                itr_pkg::REG_UPPER: upper_next = cfg_wdata[0];
                default:            radix_next = radix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= itr_pkg::RESET_RADIX;
            upper_reg <= 1'b0;
        end else begin
            radix_reg <= radix_next;
            upper_reg <= upper_next;
        end
    end

    itr_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .radix     (radix_reg),
        .upper     (upper_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_value (job_value),
        .job_ctrl  (job_ctrl)
    );

    itr_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_value (job_value),
        .job_ctrl  (job_ctrl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `ITR_ASSERT_SAME(a_base_clamped, clk, rst_n, job_valid,
        (job_ctrl.base >= itr_pkg::MIN_RADIX) && (job_ctrl.base <= itr_pkg::MAX_RADIX),
        "queued base outside 2..36")
    `ITR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, job_valid && job_ready,
        !job_ready, "converter took a new item while busy")
    `ITR_ASSERT_SAME(a_last_is_digit, clk, rst_n, m_tvalid && m_tlast,
        m_tdata != itr_pkg::CHAR_MINUS, "final character is a minus sign")

endmodule

`default_nettype wire

// ----- dv/integer_to_radix_text_tb.sv -----
`default_nettype none

module integer_to_radix_text_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 30;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } text_item_t;

    typedef struct {
        logic [5:0]  radix_w;
        logic [5:0]  upper_w;
        logic [31:0] magnitude;
        logic        is_negative;
        string       text;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = itr_pkg::REG_RADIX;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_item_t    expected_chars [$];
    directed_row_t directed_rows [$];

    logic [5:0] radix_setting = itr_pkg::RESET_RADIX;
    logic [5:0] upper_setting = '0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int numbers_sent       = 0;
    int chars_checked      = 0;
    int settings_written   = 0;
    int quiet_cycles       = 0;

    integer_to_radix_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] effective_base(input logic [5:0] radix_w);
        if (radix_w < itr_pkg::MIN_RADIX)
        begin
            return itr_pkg::MIN_RADIX;
        end
        if (radix_w > itr_pkg::MAX_RADIX)
        begin
            return itr_pkg::MAX_RADIX;
        end
        return radix_w;
    endfunction

    task automatic predict_text(input logic [31:0] magnitude, input logic is_negative);
        logic [5:0]  base;
        logic [31:0] rest;
        logic [5:0]  digits [32];
        logic [7:0]  letter_a;
        int          count;
        text_item_t  item;
        base = effective_base(radix_setting);
        letter_a = upper_setting[0] ? itr_pkg::CHAR_UPPER_A : itr_pkg::CHAR_LOWER_A;
        rest = magnitude;
        count = 0;
        // Zero still yields one digit because the loop body runs once.
        do
        begin
            digits[count] = 6'(rest % base);
            rest = rest / base;
            count++;
        end
        while (rest != 0);
        if (is_negative)
        begin
            item.text_char = itr_pkg::CHAR_MINUS;
            item.last_char = 1'b0;
            expected_chars.push_back(item);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            if (digits[i] < 6'd10)
            begin
                item.text_char = itr_pkg::CHAR_ZERO + 8'(digits[i]);
            end
            else
            begin
                item.text_char = letter_a + 8'(digits[i]) - 8'd10;
            end
            item.last_char = (i == 0);
            expected_chars.push_back(item);
        end
    endtask

    task automatic expect_text(input string text);
        text_item_t item;
        for (int i = 0; i < text.len(); i++)
        begin
            item.text_char = text[i];
            item.last_char = (i == text.len() - 1);
            expected_chars.push_back(item);
        end
    endtask

    task automatic wait_until_drained();
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [5:0] radix_w, input logic [5:0] upper_w);
        cfg_we    <= 1'b1;
        cfg_addr  <= itr_pkg::REG_RADIX;
        cfg_wdata <= radix_w;
        @(posedge clk);
        cfg_addr  <= itr_pkg::REG_UPPER;
        cfg_wdata <= upper_w;
        @(posedge clk);
        cfg_we <= 1'b0;
        radix_setting = radix_w;
        upper_setting = upper_w;
        settings_written++;
    endtask

    // An empty text means the expected characters come from the predictor.
    task automatic send_number(input logic [31:0] magnitude, input logic is_negative,
                               input string text);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 60)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= magnitude;
        s_tuser  <= is_negative;
        do
            @(posedge clk);
        while (!s_tready);
        if (text.len() == 0)
        begin
            predict_text(magnitude, is_negative);
        end
        else
        begin
            expect_text(text);
        end
        numbers_sent++;
    endtask

    function automatic logic [31:0] random_magnitude(input logic [5:0] radix_w);
        logic [63:0] power;
        logic [5:0]  base;
        int          k;
        base = effective_base(radix_w);
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $urandom_range(40);
            3: return 32'hFFFF_FFFF >> $urandom_range(31);
            4: return 32'd1 << $urandom_range(31);
            default:
            begin
                // Land on or just below a power of the base, where the digit count steps.
                power = 64'd1;
                k = $urandom_range(1, 32);
                repeat (k)
                begin
                    if (power * base <= 64'hFFFF_FFFF)
                    begin
                        power = power * base;
                    end
                end
                return 32'(power - 64'($urandom_range(1)));
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : check_text
        text_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata !== want.text_char)
                begin
                    mismatches++;
                    $display("%0t: text_char mismatch: expected %h, actual %h",
                             $time, want.text_char, m_tdata);
                end
                if (m_tlast !== want.last_char)
                begin
                    mismatches++;
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, want.last_char, m_tlast);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d characters still expected",
                     $time, QUIET_LIMIT, expected_chars.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [5:0] phase_radix [PHASES];
        logic [5:0] radix_w;
        logic [5:0] upper_w;
        phase_radix = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd63, 6'd7, 6'd10, 6'd5};
        directed_rows = '{
            '{6'd10, 6'd0,  32'd0,          1'b0, "0"},
            '{6'd10, 6'd0,  32'd0,          1'b1, "-0"},
            '{6'd10, 6'd0,  32'hFFFF_FFFF,  1'b0, "4294967295"},
            '{6'd10, 6'd0,  32'hFFFF_FFFF,  1'b1, "-4294967295"},
            '{6'd10, 6'd0,  32'd1,          1'b0, "1"},
            '{6'd10, 6'd0,  32'h8000_0000,  1'b0, "2147483648"},
            '{6'd10, 6'd0,  32'd1000000000, 1'b0, "1000000000"},
            '{6'd2,  6'd0,  32'hFFFF_FFFF,  1'b1, ""},
            '{6'd2,  6'd0,  32'd0,          1'b0, "0"},
            '{6'd2,  6'd0,  32'h5555_5555,  1'b0, ""},
            '{6'd36, 6'd0,  32'd35,         1'b0, "z"},
            '{6'd36, 6'd0,  32'hFFFF_FFFF,  1'b1, ""},
            '{6'd36, 6'd1,  32'd35,         1'b1, "-Z"},
            '{6'd36, 6'd1,  32'd1295,       1'b0, "ZZ"},
            '{6'd16, 6'd1,  32'hDEAD_BEEF,  1'b0, "DEADBEEF"},
            '{6'd16, 6'd0,  32'hDEAD_BEEF,  1'b1, "-deadbeef"},
            '{6'd0,  6'd0,  32'd5,          1'b0, "101"},
            '{6'd1,  6'd0,  32'd6,          1'b0, "110"},
            '{6'd63, 6'd0,  32'd36,         1'b0, "10"},
            '{6'd37, 6'd1,  32'd71,         1'b0, "1Z"},
            '{6'd8,  6'd0,  32'h8000_0000,  1'b0, "20000000000"},
            '{6'd7,  6'd0,  32'h1234_5678,  1'b1, ""},
            '{6'd20, 6'h3E, 32'd19,         1'b0, "j"},
            '{6'd20, 6'h21, 32'd19,         1'b0, "J"}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].radix_w != radix_setting ||
                directed_rows[i].upper_w != upper_setting)
            begin
                s_tvalid <= 1'b0;
                wait_until_drained();
                write_settings(directed_rows[i].radix_w, directed_rows[i].upper_w);
            end
            send_number(directed_rows[i].magnitude, directed_rows[i].is_negative,
                        directed_rows[i].text);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            s_tvalid <= 1'b0;
            wait_until_drained();
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 76;
                end
                default:
                begin
                    sender_idle_pct = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            radix_w = (p >= 6) ? 6'($urandom_range(63)) : phase_radix[p];
            upper_w = {5'($urandom_range(31)), 1'(p)};
            write_settings(radix_w, upper_w);
            repeat (ITEMS_PER_PHASE)
            begin
                send_number(random_magnitude(radix_w), 1'($urandom_range(1)), "");
            end
        end

        s_tvalid <= 1'b0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d characters never arrived", $time, expected_chars.size());
        end
        $display("Converted %0d numbers into %0d checked characters under %0d base settings,",
                 numbers_sent, chars_checked, settings_written);
        $display("including clamped bases, both letter cases, signs, zero and full-width values.");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
